@@ hdl/dsdpg_pkg.sv @@
// Shared types and constants of the dual step/dir pulse generator.
// Used by the divider, the wheel channel, the top level and the checker.
package dsdpg_pkg;

	localparam int POSITION_WIDTH_DEF = 32;
	localparam int PERIOD_WIDTH_DEF   = 24;
	localparam int SPEED_WIDTH_DEF    = 16;

	localparam int TICK_WIDTH     = 24;
	localparam int DEADBAND_WIDTH = 10;
	localparam int APB_DATA_WIDTH = 32;
	localparam int APB_ADDR_WIDTH = 4;

	localparam logic                      REVERSE_LEFT_RST  = 1'b1;
	localparam logic                      REVERSE_RIGHT_RST = 1'b0;
	localparam logic [DEADBAND_WIDTH-1:0] DEADBAND_RST      = 10'd10;
	localparam logic [TICK_WIDTH-1:0]     TICK_RATE_RST     = 24'd1000000;

	// Item modes.
	localparam logic [1:0] MODE_TICK  = 2'd0;
	localparam logic [1:0] MODE_SET   = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	// Register indexes, taken from paddr[3:2].
	localparam logic [1:0] REG_REVERSE_LEFT  = 2'd0;
	localparam logic [1:0] REG_REVERSE_RIGHT = 2'd1;
	localparam logic [1:0] REG_DEADBAND      = 2'd2;
	localparam logic [1:0] REG_TICK_RATE     = 2'd3;

	typedef struct packed {
		logic tick;
		logic set;
		logic clear;
	} wheel_cmd_t;

	typedef struct packed {
		logic step;
		logic dir;
		logic running;
		logic busy;
	} wheel_stat_t;

endpackage

@@ hdl/dsdpg_div.sv @@
// Restoring divider that produces one quotient bit per cycle.
// Depends on dsdpg_pkg for its default widths, TICK_WIDTH and SPEED_WIDTH_DEF.
module dsdpg_div import dsdpg_pkg::*; #(
	parameter int NUM_WIDTH = TICK_WIDTH,
	parameter int DEN_WIDTH = SPEED_WIDTH_DEF + 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [NUM_WIDTH-1:0] num,
	input  logic [DEN_WIDTH-1:0] den,
	output logic                 busy,
	output logic                 done,
	output logic [NUM_WIDTH-1:0] quot
);

	localparam int CW = (NUM_WIDTH > 1) ? $clog2(NUM_WIDTH) : 1;

	logic [NUM_WIDTH-1:0] nq_q;
	logic [DEN_WIDTH-1:0] rem_q;
	logic [DEN_WIDTH-1:0] den_q;
	logic [CW-1:0]        cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DEN_WIDTH:0]   rem_sh;
	logic [DEN_WIDTH:0]   diff;

	// The dividend shifts out at the top while quotient bits enter at the bottom.
	assign rem_sh = {rem_q, nq_q[NUM_WIDTH-1]};
	assign diff   = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NUM_WIDTH - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			nq_q  <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (!diff[DEN_WIDTH]) begin
				rem_q <= diff[DEN_WIDTH-1:0];
				nq_q  <= {nq_q[NUM_WIDTH-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[DEN_WIDTH-1:0];
				nq_q  <= {nq_q[NUM_WIDTH-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = nq_q;

endmodule

@@ hdl/dsdpg_wheel.sv @@
// One wheel channel: speed decode, half-period divider, pulse timer and position.
// Depends on dsdpg_pkg and dsdpg_div.
module dsdpg_wheel import dsdpg_pkg::*; #(
	parameter int POSITION_WIDTH = POSITION_WIDTH_DEF,
	parameter int PERIOD_WIDTH   = PERIOD_WIDTH_DEF,
	parameter int SPEED_WIDTH    = SPEED_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  wheel_cmd_t                cmd,
	input  logic [SPEED_WIDTH-1:0]    speed,
	input  logic                      reverse,
	input  logic [DEADBAND_WIDTH-1:0] deadband,
	input  logic [TICK_WIDTH-1:0]     tick_rate,
	output wheel_stat_t               stat,
	output logic [POSITION_WIDTH-1:0] pos
);

	localparam int DBW = (SPEED_WIDTH > DEADBAND_WIDTH) ? SPEED_WIDTH : DEADBAND_WIDTH;
	localparam int QW  = (TICK_WIDTH > PERIOD_WIDTH) ? TICK_WIDTH : PERIOD_WIDTH;
	localparam logic [PERIOD_WIDTH-1:0] PMAX = {PERIOD_WIDTH{1'b1}};

	logic [SPEED_WIDTH-1:0]    mag;
	logic                      neg;
	logic                      below;
	logic                      div_start;
	logic                      div_busy;
	logic                      div_done;
	logic [TICK_WIDTH-1:0]     quot;
	logic [QW-1:0]             quot_ext;
	logic [PERIOD_WIDTH-1:0]   hp_sat;
	logic [PERIOD_WIDTH:0]     count_next;

	logic [PERIOD_WIDTH-1:0]   count_q;
	logic [PERIOD_WIDTH-1:0]   hp_q;
	logic                      running_q;
	logic                      step_q;
	logic                      backward_q;
	logic                      dir_q;
	logic [POSITION_WIDTH-1:0] pos_q;

	// The most negative speed negates to itself, which read unsigned is its magnitude.
	assign neg       = speed[SPEED_WIDTH-1];
	assign mag       = neg ? (~speed + SPEED_WIDTH'(1)) : speed;
	assign below     = DBW'(mag) < DBW'(deadband);
	assign div_start = cmd.set && !below && (mag != '0);

	dsdpg_div #(
		.NUM_WIDTH(TICK_WIDTH),
		.DEN_WIDTH(SPEED_WIDTH + 1)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (tick_rate),
		.den   ({mag, 1'b0}),
		.busy  (div_busy),
		.done  (div_done),
		.quot  (quot)
	);

	assign quot_ext   = QW'(quot);
	assign hp_sat     = (quot_ext > QW'(PMAX)) ? PMAX : quot_ext[PERIOD_WIDTH-1:0];
	assign count_next = {1'b0, count_q} + (PERIOD_WIDTH + 1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			hp_q       <= '0;
			running_q  <= 1'b0;
			step_q     <= 1'b0;
			backward_q <= 1'b0;
			dir_q      <= 1'b0;
			pos_q      <= '0;
		end else begin
			if (cmd.set) begin
				if (below) begin
					running_q <= 1'b0;
				end else begin
					backward_q <= neg;
					dir_q      <= reverse ? neg : (!neg && (mag != '0));
					// A zero speed that passes the deadband runs at the longest period.
					if (mag == '0) begin
						hp_q      <= PMAX;
						running_q <= 1'b1;
					end
				end
			end
			if (div_done) begin
				hp_q      <= hp_sat;
				running_q <= 1'b1;
			end
			if (cmd.tick && running_q) begin
				if (count_next >= {1'b0, hp_q}) begin
					count_q <= '0;
					step_q  <= !step_q;
					if (!step_q) begin
						pos_q <= pos_q + (backward_q ? {POSITION_WIDTH{1'b1}}
						                             : POSITION_WIDTH'(1));
					end
				end else begin
					count_q <= count_next[PERIOD_WIDTH-1:0];
				end
			end
			if (cmd.clear) begin
				pos_q <= '0;
			end
		end
	end

	assign stat.step    = step_q;
	assign stat.dir     = dir_q;
	assign stat.running = running_q;
	assign stat.busy    = div_busy || div_done;
	assign pos          = pos_q;

endmodule

@@ hdl/dual_step_dir_pulse_generator.sv @@
// Dual-wheel step/dir pulse generator: APB registers, item sequencer, result register.
// Depends on dsdpg_pkg and dsdpg_wheel.
//
// Usage: each input transaction on in_valid/in_ready carries a mode. A tick advances
// both running pulse timers, a set command loads new signed speeds for both wheels,
// a clear zeroes both positions, and the unused mode only reports the state. Every
// input transaction produces exactly one output transaction on out_valid/out_ready
// with the pin levels, positions and timer states after the item took effect.
// Tick, clear and report items go from the idle state straight to the done state, and
// their result is registered from there. A set item first waits in the divide state:
// the two per-wheel restoring dividers run in parallel and form one bit of the 24-bit
// half-period quotient per cycle, and the result is registered once both have finished.
// One item is in work at a time, so the input is not ready for the next item until the
// result of the last one has been loaded into the output register.
// A finished result waits in the output register; the next item is still accepted and
// worked on, but its result is held until the receiver takes the waiting one.
// Reset clears both wheels, the positions and the output valid flag and restores the
// register defaults (left reversed, deadband 10, 1000000 ticks per second).
module dual_step_dir_pulse_generator import dsdpg_pkg::*; #(
	parameter int POSITION_WIDTH = POSITION_WIDTH_DEF,
	parameter int PERIOD_WIDTH   = PERIOD_WIDTH_DEF,
	parameter int SPEED_WIDTH    = SPEED_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [APB_ADDR_WIDTH-1:0]        paddr,
	input  logic [APB_DATA_WIDTH-1:0]        pwdata,
	output logic [APB_DATA_WIDTH-1:0]        prdata,
	output logic                             pready,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       mode,
	input  logic signed [SPEED_WIDTH-1:0]    left_speed,
	input  logic signed [SPEED_WIDTH-1:0]    right_speed,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             step_left_pin,
	output logic                             dir_left_pin,
	output logic                             step_right_pin,
	output logic                             dir_right_pin,
	output logic signed [POSITION_WIDTH-1:0] steps_left,
	output logic signed [POSITION_WIDTH-1:0] steps_right,
	output logic                             left_active,
	output logic                             right_active
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]                state_q;
	logic [1:0]                state_d;
	logic                      rev_l_q;
	logic                      rev_r_q;
	logic [DEADBAND_WIDTH-1:0] deadband_q;
	logic [TICK_WIDTH-1:0]     tick_rate_q;
	logic                      cfg_wr;
	logic                      accept;
	logic                      load;
	wheel_cmd_t                cmd;
	wheel_stat_t               stat_l;
	wheel_stat_t               stat_r;
	logic [POSITION_WIDTH-1:0] pos_l;
	logic [POSITION_WIDTH-1:0] pos_r;

	logic                      out_valid_q;
	logic                      step_l_q;
	logic                      dir_l_q;
	logic                      step_r_q;
	logic                      dir_r_q;
	logic [POSITION_WIDTH-1:0] pos_l_q;
	logic [POSITION_WIDTH-1:0] pos_r_q;
	logic                      act_l_q;
	logic                      act_r_q;

	// Configuration registers.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rev_l_q     <= REVERSE_LEFT_RST;
			rev_r_q     <= REVERSE_RIGHT_RST;
			deadband_q  <= DEADBAND_RST;
			tick_rate_q <= TICK_RATE_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_REVERSE_LEFT:  rev_l_q     <= pwdata[0];
				REG_REVERSE_RIGHT: rev_r_q     <= pwdata[0];
				REG_DEADBAND:      deadband_q  <= pwdata[DEADBAND_WIDTH-1:0];
				REG_TICK_RATE:     tick_rate_q <= pwdata[TICK_WIDTH-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_REVERSE_LEFT:  prdata = APB_DATA_WIDTH'(rev_l_q);
			REG_REVERSE_RIGHT: prdata = APB_DATA_WIDTH'(rev_r_q);
			REG_DEADBAND:      prdata = APB_DATA_WIDTH'(deadband_q);
			REG_TICK_RATE:     prdata = APB_DATA_WIDTH'(tick_rate_q);
		endcase
	end

	// Item sequencer.
	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign cmd.tick  = accept && (mode == MODE_TICK);
	assign cmd.set   = accept && (mode == MODE_SET);
	assign cmd.clear = accept && (mode == MODE_CLEAR);
	assign load      = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (mode == MODE_SET) ? ST_DIV : ST_DONE;
				end
			end
			ST_DIV: begin
				if (!stat_l.busy && !stat_r.busy) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	dsdpg_wheel #(
		.POSITION_WIDTH(POSITION_WIDTH),
		.PERIOD_WIDTH  (PERIOD_WIDTH),
		.SPEED_WIDTH   (SPEED_WIDTH)
	) u_wheel_left (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.speed    (left_speed),
		.reverse  (rev_l_q),
		.deadband (deadband_q),
		.tick_rate(tick_rate_q),
		.stat     (stat_l),
		.pos      (pos_l)
	);

	dsdpg_wheel #(
		.POSITION_WIDTH(POSITION_WIDTH),
		.PERIOD_WIDTH  (PERIOD_WIDTH),
		.SPEED_WIDTH   (SPEED_WIDTH)
	) u_wheel_right (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.speed    (right_speed),
		.reverse  (rev_r_q),
		.deadband (deadband_q),
		.tick_rate(tick_rate_q),
		.stat     (stat_r),
		.pos      (pos_r)
	);

	// Result register: a snapshot of both wheels once the item has fully taken effect.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			step_l_q <= stat_l.step;
			dir_l_q  <= stat_l.dir;
			step_r_q <= stat_r.step;
			dir_r_q  <= stat_r.dir;
			pos_l_q  <= pos_l;
			pos_r_q  <= pos_r;
			act_l_q  <= stat_l.running;
			act_r_q  <= stat_r.running;
		end
	end

	assign out_valid      = out_valid_q;
	assign step_left_pin  = step_l_q;
	assign dir_left_pin   = dir_l_q;
	assign step_right_pin = step_r_q;
	assign dir_right_pin  = dir_r_q;
	assign steps_left     = pos_l_q;
	assign steps_right    = pos_r_q;
	assign left_active    = act_l_q;
	assign right_active   = act_r_q;

endmodule

@@ hdl/dsdpg_chk.sv @@
// Port-level checker for the dual step/dir pulse generator, bound to the top level.
// Depends on dsdpg_pkg for the mode codes.
module dsdpg_chk import dsdpg_pkg::*; #(
	parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic [1:0]                       mode,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic                             step_left_pin,
	input logic signed [POSITION_WIDTH-1:0] steps_left,
	input logic signed [POSITION_WIDTH-1:0] steps_right
);

	// A stalled result stays valid and keeps its left position and left step level.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(steps_left)
		&& $stable(step_left_pin))
		else $error("stalled result changed");

	// A set command blocks the input while the dividers run.
	a_set_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (mode == MODE_SET) |=> !in_ready)
		else $error("input accepted during half-period division");

	// A tick, clear or report item accepted while the output register is free reaches
	// out_valid through the done state and the result register.
	a_short_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (mode != MODE_SET) && (!out_valid || out_ready)
		|=> ##1 out_valid)
		else $error("result of a short item is late");

	// A clear item reports both positions as zero.
	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (mode == MODE_CLEAR) && (!out_valid || out_ready)
		|=> ##1 (steps_left == '0) && (steps_right == '0))
		else $error("positions not cleared");

endmodule

bind dual_step_dir_pulse_generator dsdpg_chk #(
	.POSITION_WIDTH(POSITION_WIDTH)
) u_dsdpg_chk (.*);

@@ sim/tb_dual_step_dir_pulse_generator.sv @@
// Testbench for the dual step/dir pulse generator: random and directed commands,
// with an item-level model of both wheels checking every result transaction.
// Depends on dsdpg_pkg and the dual_step_dir_pulse_generator RTL.
`timescale 1ns / 1ps

module tb_dual_step_dir_pulse_generator import dsdpg_pkg::*; ();

	typedef struct packed {
		logic        step_l;
		logic        dir_l;
		logic        step_r;
		logic        dir_r;
		logic [31:0] pos_l;
		logic [31:0] pos_r;
		logic        act_l;
		logic        act_r;
	} pin_state_t;

	typedef struct packed {
		logic [23:0] count;
		logic [23:0] half;
		logic        running;
		logic        level;
		logic        backward;
		logic        dir;
		logic [31:0] pos;
	} wheel_model_t;

	class wheel_pair_model;
		logic         rev_left;
		logic         rev_right;
		logic [9:0]   deadband;
		logic [23:0]  tick_rate;
		wheel_model_t left;
		wheel_model_t right;
		pin_state_t   pins_due[$];
		int           mismatch_count;
		int           results_seen;

		function new();
			rev_left       = REVERSE_LEFT_RST;
			rev_right      = REVERSE_RIGHT_RST;
			deadband       = DEADBAND_RST;
			tick_rate      = TICK_RATE_RST;
			left           = '0;
			right          = '0;
			mismatch_count = 0;
			results_seen   = 0;
		endfunction

		function int pending();
			return pins_due.size();
		endfunction

		function void set_reg(logic [1:0] idx, logic [31:0] value);
			case (idx)
				REG_REVERSE_LEFT: rev_left = value[0];
				REG_REVERSE_RIGHT: rev_right = value[0];
				REG_DEADBAND: deadband = value[9:0];
				REG_TICK_RATE: tick_rate = value[23:0];
				default: ;
			endcase
		endfunction

		function wheel_model_t apply_speed(wheel_model_t w, logic [15:0] spd, logic rev);
			logic [16:0] mag;
			logic        neg;
			logic [31:0] quot;
			neg = spd[15];
			mag = neg ? 17'd0 - {spd[15], spd} : {1'b0, spd};
			// Below the deadband only the timer stops; pins, count and direction hold.
			if (mag < {7'd0, deadband}) begin
				w.running = 1'b0;
				return w;
			end
			w.backward = neg;
			w.dir = rev ? neg : (!neg && mag != 17'd0);
			if (mag == 17'd0) begin
				w.half = '1;
			end else begin
				quot = {8'd0, tick_rate} / {14'd0, mag, 1'b0};
				w.half = (quot > 32'hFFFFFF) ? 24'hFFFFFF : quot[23:0];
			end
			w.running = 1'b1;
			return w;
		endfunction

		function wheel_model_t advance(wheel_model_t w);
			if (!w.running)
				return w;
			if ({1'b0, w.count} + 25'd1 >= {1'b0, w.half}) begin
				w.count = '0;
				if (!w.level) begin
					w.pos = w.backward ? w.pos - 32'd1 : w.pos + 32'd1;
					w.level = 1'b1;
				end else begin
					w.level = 1'b0;
				end
			end else begin
				w.count = w.count + 24'd1;
			end
			return w;
		endfunction

		function void apply_command(logic [1:0] m, logic [15:0] sl, logic [15:0] sr);
			pin_state_t due;
			case (m)
				MODE_TICK: begin
					left = advance(left);
					right = advance(right);
				end
				MODE_SET: begin
					left = apply_speed(left, sl, rev_left);
					right = apply_speed(right, sr, rev_right);
				end
				MODE_CLEAR: begin
					left.pos = '0;
					right.pos = '0;
				end
				default: ;
			endcase
			due.step_l = left.level;
			due.dir_l  = left.dir;
			due.step_r = right.level;
			due.dir_r  = right.dir;
			due.pos_l  = left.pos;
			due.pos_r  = right.pos;
			due.act_l  = left.running;
			due.act_r  = right.running;
			pins_due.push_back(due);
		endfunction

		task flag_mismatch(string what);
			mismatch_count++;
			$display("mismatch: %s", what);
		endtask

		task compare_field(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				flag_mismatch($sformatf("%s got %0h, want %0h (result %0d)",
					name, got, want, results_seen));
		endtask

		task check_pins(pin_state_t seen);
			pin_state_t due;
			if (pins_due.size() == 0) begin
				flag_mismatch("result transaction with no command waiting");
				return;
			end
			due = pins_due.pop_front();
			compare_field("step_left_pin", 32'(seen.step_l), 32'(due.step_l));
			compare_field("dir_left_pin", 32'(seen.dir_l), 32'(due.dir_l));
			compare_field("step_right_pin", 32'(seen.step_r), 32'(due.step_r));
			compare_field("dir_right_pin", 32'(seen.dir_r), 32'(due.dir_r));
			compare_field("steps_left", seen.pos_l, due.pos_l);
			compare_field("steps_right", seen.pos_r, due.pos_r);
			compare_field("left_active", 32'(seen.act_l), 32'(due.act_l));
			compare_field("right_active", 32'(seen.act_r), 32'(due.act_r));
			results_seen++;
		endtask
	endclass

	localparam logic [1:0] MODE_REPORT = 2'd3;
	localparam int CYCLE_LIMIT = 200000;

	logic                      clk;
	logic                      arst_n;
	logic                      psel;
	logic                      penable;
	logic                      pwrite;
	logic [APB_ADDR_WIDTH-1:0] paddr;
	logic [APB_DATA_WIDTH-1:0] pwdata;
	logic [APB_DATA_WIDTH-1:0] prdata;
	logic                      pready;
	logic                      in_valid;
	logic                      in_ready;
	logic [1:0]                mode;
	logic signed [15:0]        left_speed;
	logic signed [15:0]        right_speed;
	logic                      out_valid;
	logic                      out_ready;
	logic                      step_left_pin;
	logic                      dir_left_pin;
	logic                      step_right_pin;
	logic                      dir_right_pin;
	logic signed [31:0]        steps_left;
	logic signed [31:0]        steps_right;
	logic                      left_active;
	logic                      right_active;

	logic            calm;
	logic [9:0]      cur_deadband;
	int              cycle_count = 0;
	wheel_pair_model model;

	dual_step_dir_pulse_generator dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.left_speed(left_speed),
		.right_speed(right_speed),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.step_left_pin(step_left_pin),
		.dir_left_pin(dir_left_pin),
		.step_right_pin(step_right_pin),
		.dir_right_pin(dir_right_pin),
		.steps_left(steps_left),
		.steps_right(steps_right),
		.left_active(left_active),
		.right_active(right_active)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("simulation failed");
		$finish;
	end

	// All tasks below start and end at a falling edge.
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		model.set_reg(idx, value);
		if (idx == REG_DEADBAND)
			cur_deadband = value[9:0];
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic send_item(input logic [1:0] m, input logic [15:0] sl, input logic [15:0] sr);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		in_valid = 1'b1;
		mode = m;
		left_speed = sl;
		right_speed = sr;
		do @(posedge clk); while (!in_ready);
		model.apply_command(m, sl, sr);
		@(negedge clk);
	endtask

	task automatic send_tick();
		send_item(MODE_TICK, 16'($urandom), 16'($urandom));
	endtask

	task automatic wait_idle();
		in_valid = 1'b0;
		while (model.pending() != 0) @(negedge clk);
	endtask

	function automatic logic [15:0] pick_speed(int band);
		int kind;
		int mag;
		kind = $urandom_range(0, 9);
		if (kind < 3)
			return 16'($urandom);
		if (kind < 6)
			mag = $urandom_range(0, band + 3);
		else
			mag = $urandom_range(1, 600);
		return ($urandom_range(0, 1) == 1) ? 16'(-mag) : 16'(mag);
	endfunction

	initial begin
		int stall_left;
		stall_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left == 0 && !calm && $urandom_range(0, 5) == 0)
				stall_left = $urandom_range(1, 9);
			if (stall_left > 0) begin
				out_ready = 1'b0;
				stall_left--;
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			model.check_pins({step_left_pin, dir_left_pin, step_right_pin, dir_right_pin,
				steps_left, steps_right, left_active, right_active});
	end

	initial begin
		int         phase;
		int         n;
		int         pick;
		logic [9:0] band;
		logic [23:0] rate;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		mode = MODE_TICK;
		left_speed = '0;
		right_speed = '0;
		calm = 1'b1;
		cur_deadband = DEADBAND_RST;
		model = new();
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Default registers: full-scale speeds both ways, the deadband edge, stopping.
		send_item(MODE_REPORT, 16'h1234, 16'hFEDC);
		send_tick();
		send_item(MODE_SET, 16'sh8000, 16'sh7FFF);
		send_tick();
		send_tick();
		send_item(MODE_SET, 16'sd9, -16'sd10);
		send_tick();
		send_item(MODE_CLEAR, 16'h5A5A, 16'hA5A5);
		wait_idle();

		// No deadband and no tick rate: zero speed runs with a saturated half period,
		// and any other speed toggles on every tick.
		write_reg(REG_REVERSE_LEFT, 32'd0);
		write_reg(REG_REVERSE_RIGHT, 32'd1);
		write_reg(REG_DEADBAND, 32'd0);
		write_reg(REG_TICK_RATE, 32'd0);
		send_item(MODE_SET, 16'sd0, 16'sd0);
		send_tick();
		send_item(MODE_SET, 16'sd100, -16'sd1);
		repeat (3) send_tick();
		send_item(MODE_CLEAR, 16'sd100, -16'sd1);
		wait_idle();

		// Half period cut below the running count, then stop and restart from the held count.
		write_reg(REG_REVERSE_LEFT, 32'd1);
		write_reg(REG_REVERSE_RIGHT, 32'd0);
		write_reg(REG_DEADBAND, 32'd1);
		write_reg(REG_TICK_RATE, 32'd1000);
		send_item(MODE_SET, 16'sd1, -16'sd1);
		repeat (4) send_tick();
		send_item(MODE_SET, 16'sd500, -16'sd300);
		send_tick();
		send_item(MODE_SET, 16'sd0, 16'sd0);
		send_tick();
		send_item(MODE_SET, 16'sd2, 16'sd2);
		send_tick();

		for (phase = 0; phase < 8; phase++) begin
			wait_idle();
			calm = (phase == 7) || ($urandom_range(0, 3) == 0);
			if (phase == 0)
				band = 10'd1023;
			else if (phase == 1)
				band = 10'd0;
			else if ($urandom_range(0, 3) == 0)
				band = 10'($urandom_range(1, 1000));
			else
				band = 10'($urandom_range(0, 40));
			pick = $urandom_range(0, 9);
			if (phase == 0)
				rate = 24'hFFFFFF;
			else if (phase == 1)
				rate = 24'd0;
			else if (pick == 0)
				rate = 24'd1;
			else if (pick == 1)
				rate = 24'($urandom_range(100000, 10000000));
			else
				rate = 24'($urandom_range(2, 5000));
			write_reg(REG_REVERSE_LEFT, 32'($urandom_range(0, 1)));
			write_reg(REG_REVERSE_RIGHT, 32'($urandom_range(0, 1)));
			write_reg(REG_DEADBAND, {22'd0, band});
			write_reg(REG_TICK_RATE, {8'd0, rate});
			for (n = 0; n < 60; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 68)
					send_tick();
				else if (pick < 84)
					send_item(MODE_SET, pick_speed(int'(cur_deadband)),
						pick_speed(int'(cur_deadband)));
				else if (pick < 92)
					send_item(MODE_CLEAR, 16'($urandom), 16'($urandom));
				else
					send_item(MODE_REPORT, 16'($urandom), 16'($urandom));
			end
		end

		wait_idle();
		repeat (30) @(negedge clk);
		if (model.mismatch_count == 0 && model.pending() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
